// File: src/sism_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constants for the stationary inactivity state machine.
// No dependencies; imported by every module of the block.

package sism_pkg;

    // Field widths
    localparam int OP_W     = 2;
    localparam int SAMPLE_W = 16;
    localparam int MODE_W   = 2;
    localparam int COUNT_W  = 8;
    localparam int DIST_W   = 18;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;

    // Stream word widths, padded to whole bytes
    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 32;

    // Operation codes carried on the input tuser
    localparam logic [OP_W-1:0] OP_TICK    = 2'd0;
    localparam logic [OP_W-1:0] OP_TAP     = 2'd1;
    localparam logic [OP_W-1:0] OP_SW_WAKE = 2'd2;
    localparam logic [OP_W-1:0] OP_REEVAL  = 2'd3;

    // Mode (state) codes
    localparam logic [MODE_W-1:0] MODE_AWAKE      = 2'd0;
    localparam logic [MODE_W-1:0] MODE_STATIONARY = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PEEKING    = 2'd2;
    localparam logic [MODE_W-1:0] MODE_DISABLED   = 2'd3;

    // Internal transition requests
    localparam logic [1:0] REQ_SLEEP   = 2'd0;
    localparam logic [1:0] REQ_WAKE    = 2'd1;
    localparam logic [1:0] REQ_ENABLE  = 2'd2;
    localparam logic [1:0] REQ_DISABLE = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WAIT_MINUTES    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PEEK_MINUTES    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_THRESHOLD  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FEATURE_ENABLED = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RUNLEVEL_ALLOW  = 3'd4;

    // Reset values
    localparam logic [COUNT_W-1:0] WAIT_MINUTES_RST   = 8'd30;
    localparam logic [COUNT_W-1:0] PEEK_MINUTES_RST   = 8'd5;
    localparam logic [DIST_W-1:0]  IDLE_THRESHOLD_RST = 18'd50;
    localparam logic [MODE_W-1:0]  MODE_RST           = MODE_DISABLED;
    localparam logic [COUNT_W-1:0] COUNT_RST          = 8'd30;

    typedef struct packed {
        logic [COUNT_W-1:0] wait_minutes;
        logic [COUNT_W-1:0] peek_minutes;
        logic [DIST_W-1:0]  idle_threshold;
        logic               feature_enabled;
        logic               runlevel_allow;
    } cfg_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] x;
        logic signed [SAMPLE_W-1:0] y;
        logic signed [SAMPLE_W-1:0] z;
    } sample_t;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [COUNT_W-1:0] minutes_left;
        logic [DIST_W-1:0]  motion_distance;
    } result_t;

endpackage

// File: src/stationary_inactivity_state_machine_top.sv
`timescale 1ns / 1ps
// Stationary inactivity state machine, top level with stream ports.
// An accepted word goes to the input register, its result to the output register.
// Throughput: one word per cycle unless the output stalls; state update and result
// are one pass of logic between the input register and the output register.
// Reset: async active low; mode disabled, countdown 30, stored sample zero,
// registers at their defaults, both stream registers empty.

module stationary_inactivity_state_machine_top (
    input  logic                             clk,
    input  logic                             rst_n,
    // Configuration write port
    input  logic                             cfg_we,
    input  logic [sism_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sism_pkg::CFG_DATA_W-1:0]  cfg_data,
    // Input stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [sism_pkg::S_TDATA_W-1:0]   s_tdata,  // accel_x, accel_y, accel_z, usb_powered, pad
    input  logic [sism_pkg::OP_W-1:0]        s_tuser,  // operation
    // Output stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [sism_pkg::M_TDATA_W-1:0]   m_tdata   // mode, minutes_left, motion_distance,
                                                       // high_sensitivity, pad
);
    import sism_pkg::*;

    logic              in_vld_reg;
    logic [OP_W-1:0]   in_op_reg;
    sample_t           in_sample_reg;
    logic              in_usb_reg;

    logic              out_vld_reg;
    result_t           out_res_reg;

    logic              fire;
    cfg_t              cfg;
    result_t           result;

    sism_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Process the held word when the output register is free or draining
    assign fire     = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || fire;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_op_reg       <= s_tuser;
            in_sample_reg.x <= s_tdata[15:0];
            in_sample_reg.y <= s_tdata[31:16];
            in_sample_reg.z <= s_tdata[47:32];
            in_usb_reg      <= s_tdata[48];
        end
    end

    sism_fsm u_fsm (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (fire),
        .op          (in_op_reg),
        .sample      (in_sample_reg),
        .usb_powered (in_usb_reg),
        .cfg         (cfg),
        .result      (result)
    );

    // Output register: load on fire, drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_res_reg <= result;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {3'b000,
                       (out_res_reg.mode == MODE_STATIONARY),
                       out_res_reg.motion_distance,
                       out_res_reg.minutes_left,
                       out_res_reg.mode};

endmodule

// File: src/sism_cfg.sv
`timescale 1ns / 1ps
// Configuration register file: five write-only settings with reset defaults.
// Depends on sism_pkg.

module sism_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [sism_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sism_pkg::CFG_DATA_W-1:0] cfg_data,
    output sism_pkg::cfg_t                 cfg
);
    import sism_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the register index; unknown indexes leave everything unchanged
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_WAIT_MINUTES:    cfg_next.wait_minutes    = cfg_data[COUNT_W-1:0];
                CFG_PEEK_MINUTES:    cfg_next.peek_minutes    = cfg_data[COUNT_W-1:0];
                CFG_IDLE_THRESHOLD:  cfg_next.idle_threshold  = cfg_data[DIST_W-1:0];
                CFG_FEATURE_ENABLED: cfg_next.feature_enabled = cfg_data[0];
                CFG_RUNLEVEL_ALLOW:  cfg_next.runlevel_allow  = cfg_data[0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.wait_minutes    <= WAIT_MINUTES_RST;
            cfg_reg.peek_minutes    <= PEEK_MINUTES_RST;
            cfg_reg.idle_threshold  <= IDLE_THRESHOLD_RST;
            cfg_reg.feature_enabled <= 1'b1;
            cfg_reg.runlevel_allow  <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: src/sism_dist.sv
`timescale 1ns / 1ps
// L1 distance between two signed three-axis samples.
// Depends on sism_pkg.

module sism_dist (
    input  sism_pkg::sample_t              prev,
    input  sism_pkg::sample_t              cur,
    output logic [sism_pkg::DIST_W-1:0]    distance
);
    import sism_pkg::*;

    logic signed [SAMPLE_W:0] dx, dy, dz;
    logic [SAMPLE_W-1:0]      ax, ay, az;

    // Differences in one extra bit so they never overflow
    assign dx = {cur.x[SAMPLE_W-1], cur.x} - {prev.x[SAMPLE_W-1], prev.x};
    assign dy = {cur.y[SAMPLE_W-1], cur.y} - {prev.y[SAMPLE_W-1], prev.y};
    assign dz = {cur.z[SAMPLE_W-1], cur.z} - {prev.z[SAMPLE_W-1], prev.z};

    // Magnitudes fit in 16 bits: at most 65535 per axis
    logic [SAMPLE_W:0] nx, ny, nz;
    assign nx = -dx;
    assign ny = -dy;
    assign nz = -dz;
    assign ax = dx[SAMPLE_W] ? nx[SAMPLE_W-1:0] : dx[SAMPLE_W-1:0];
    assign ay = dy[SAMPLE_W] ? ny[SAMPLE_W-1:0] : dy[SAMPLE_W-1:0];
    assign az = dz[SAMPLE_W] ? nz[SAMPLE_W-1:0] : dz[SAMPLE_W-1:0];

    // Sum of three 16-bit magnitudes fits in 18 bits
    assign distance = {2'b00, ax} + {2'b00, ay} + {2'b00, az};

endmodule

// File: src/sism_fsm.sv
`timescale 1ns / 1ps
// Mode state machine, countdown and stored sample; forms the next result word.
// Depends on sism_pkg and sism_dist.

module sism_fsm (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          fire,
    input  logic [sism_pkg::OP_W-1:0]     op,
    input  sism_pkg::sample_t             sample,
    input  logic                          usb_powered,
    input  sism_pkg::cfg_t                cfg,
    output sism_pkg::result_t             result
);
    import sism_pkg::*;

    logic [MODE_W-1:0]  mode_reg, mode_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    sample_t            prev_reg, prev_next;

    logic [DIST_W-1:0]  distance;
    logic [DIST_W-1:0]  dist_out;
    logic [COUNT_W-1:0] count_step;
    logic               req_vld;
    logic [1:0]         req;
    logic               allowed;

    sism_dist u_dist (
        .prev     (prev_reg),
        .cur      (sample),
        .distance (distance)
    );

    assign allowed = cfg.feature_enabled & cfg.runlevel_allow;

    // Decode the operation into a request, a countdown step or nothing
    always_comb
    begin
        req_vld    = 1'b0;
        req        = REQ_SLEEP;
        dist_out   = '0;
        prev_next  = prev_reg;
        count_step = count_reg;
        unique case (op)
            OP_TICK:
            begin
                if (mode_reg != MODE_DISABLED)
                begin
                    dist_out  = distance;
                    prev_next = sample;
                    if (distance < cfg.idle_threshold)
                    begin
                        if (count_reg != '0)
                        begin
                            count_step = count_reg - 1'b1;
                        end
                        else
                        begin
                            req_vld = 1'b1;
                            req     = REQ_SLEEP;
                        end
                    end
                    else
                    begin
                        req_vld = 1'b1;
                        req     = REQ_WAKE;
                    end
                end
            end
            OP_TAP:
            begin
                req_vld = 1'b1;
                req     = REQ_WAKE;
            end
            OP_SW_WAKE:
            begin
                req_vld = allowed;
                req     = REQ_WAKE;
            end
            OP_REEVAL:
            begin
                req_vld = 1'b1;
                req     = (!usb_powered && allowed) ? REQ_ENABLE : REQ_DISABLE;
            end
            default:
            begin
                req_vld = 1'b0;
            end
        endcase
    end

    // Apply the request to the current mode
    always_comb
    begin
        mode_next  = mode_reg;
        count_next = count_step;
        if (req_vld)
        begin
            unique case (mode_reg)
                MODE_AWAKE:
                begin
                    if (req == REQ_SLEEP)
                        mode_next = MODE_STATIONARY;
                    else if (req == REQ_WAKE)
                        count_next = cfg.wait_minutes;
                    else if (req == REQ_DISABLE)
                        mode_next = MODE_DISABLED;
                end
                MODE_STATIONARY:
                begin
                    if (req == REQ_WAKE)
                    begin
                        count_next = cfg.peek_minutes;
                        mode_next  = MODE_PEEKING;
                    end
                    else if (req == REQ_DISABLE)
                        mode_next = MODE_DISABLED;
                end
                MODE_PEEKING:
                begin
                    if (req == REQ_SLEEP)
                        mode_next = MODE_STATIONARY;
                    else if (req == REQ_WAKE)
                    begin
                        count_next = cfg.wait_minutes;
                        mode_next  = MODE_AWAKE;
                    end
                    else if (req == REQ_DISABLE)
                        mode_next = MODE_DISABLED;
                end
                MODE_DISABLED:
                begin
                    if (req == REQ_ENABLE)
                    begin
                        count_next = cfg.wait_minutes;
                        mode_next  = MODE_AWAKE;
                    end
                end
                default:
                begin
                    mode_next = mode_reg;
                end
            endcase
        end
    end

    // Advance state only when the word is processed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_RST;
            count_reg <= COUNT_RST;
            prev_reg  <= '0;
        end
        else if (fire)
        begin
            mode_reg  <= mode_next;
            count_reg <= count_next;
            prev_reg  <= prev_next;
        end
    end

    assign result.mode            = mode_next;
    assign result.minutes_left    = count_next;
    assign result.motion_distance = dist_out;

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the stationary inactivity state machine top level.
// Drives the input stream and register port, predicts result words from a local
// model of the detector or a typed-in table, compares field by field; needs sism_pkg.

module tb;
    import sism_pkg::*;

    // Register indexes past the last register; writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 3'd7;
    localparam int unsigned QUIET_LIMIT = 4000;
    localparam int unsigned CHUNK_WORDS = 125;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [COUNT_W-1:0] mins;
        logic [DIST_W-1:0]  motion;
        logic               hs;
    } status_t;

    typedef struct packed {
        bit                    is_reg;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] val;
        logic [OP_W-1:0]       op;
        logic [SAMPLE_W-1:0]   x;
        logic [SAMPLE_W-1:0]   y;
        logic [SAMPLE_W-1:0]   z;
        logic                  usb;
        bit                    known;
        status_t               st;
    } plan_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic [OP_W-1:0]       s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;

    // Local copy of the detector state and its registers
    logic [MODE_W-1:0]          det_mode = MODE_DISABLED;
    logic [COUNT_W-1:0]         det_count = 8'd30;
    logic signed [SAMPLE_W-1:0] det_px = '0;
    logic signed [SAMPLE_W-1:0] det_py = '0;
    logic signed [SAMPLE_W-1:0] det_pz = '0;
    logic [COUNT_W-1:0]         det_wait_min = 8'd30;
    logic [COUNT_W-1:0]         det_peek_min = 8'd5;
    logic [DIST_W-1:0]          det_threshold = 18'd50;
    logic                       det_feature = 1'b1;
    logic                       det_runlevel = 1'b0;

    status_t     awaited_status[$];
    plan_row_t   plan[$];
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned mismatches = 0;
    int unsigned words_sent = 0;
    int unsigned results_seen = 0;
    int unsigned reg_writes = 0;
    int unsigned sleeps = 0;
    int unsigned peeks = 0;
    int unsigned quiet = 0;

    stationary_inactivity_state_machine_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // accel_x, accel_y, accel_z, usb_powered, pad
        .s_tuser   (s_tuser),   // operation
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)    // mode, minutes_left, motion_distance, high_sensitivity, pad
    );

    always #1 clk = ~clk;

    // Apply one sleep/wake/enable/disable request to the local mode
    function automatic void request_move(input logic [1:0] req);
        case (det_mode)
            MODE_AWAKE:
            begin
                if (req == REQ_SLEEP)
                begin
                    det_mode = MODE_STATIONARY;
                    sleeps++;
                end
                else if (req == REQ_WAKE)
                    det_count = det_wait_min;
                else if (req == REQ_DISABLE)
                    det_mode = MODE_DISABLED;
            end
            MODE_STATIONARY:
            begin
                if (req == REQ_WAKE)
                begin
                    det_count = det_peek_min;
                    det_mode = MODE_PEEKING;
                    peeks++;
                end
                else if (req == REQ_DISABLE)
                    det_mode = MODE_DISABLED;
            end
            MODE_PEEKING:
            begin
                if (req == REQ_SLEEP)
                begin
                    det_mode = MODE_STATIONARY;
                    sleeps++;
                end
                else if (req == REQ_WAKE)
                begin
                    det_count = det_wait_min;
                    det_mode = MODE_AWAKE;
                end
                else if (req == REQ_DISABLE)
                    det_mode = MODE_DISABLED;
            end
            default:
            begin
                if (req == REQ_ENABLE)
                begin
                    det_count = det_wait_min;
                    det_mode = MODE_AWAKE;
                end
            end
        endcase
    endfunction

    function automatic int unsigned axis_gap(input logic signed [SAMPLE_W-1:0] a,
                                             input logic signed [SAMPLE_W-1:0] b);
        int sa;
        int sb;
        sa = a;
        sb = b;
        return (sa >= sb) ? sa - sb : sb - sa;
    endfunction

    // Advance the local detector by one input word and return its status word
    function automatic status_t step_detector(input logic [OP_W-1:0] op,
                                              input logic [SAMPLE_W-1:0] x,
                                              input logic [SAMPLE_W-1:0] y,
                                              input logic [SAMPLE_W-1:0] z,
                                              input logic usb);
        status_t     st;
        int unsigned motion;
        logic        allowed;
        motion = 0;
        allowed = det_feature && det_runlevel;
        case (op)
            OP_TICK:
            begin
                // ticks leave the state and stored sample untouched while disabled
                if (det_mode != MODE_DISABLED)
                begin
                    motion = axis_gap(det_px, x) + axis_gap(det_py, y) + axis_gap(det_pz, z);
                    det_px = x;
                    det_py = y;
                    det_pz = z;
                    if (motion < det_threshold)
                    begin
                        if (det_count != 0)
                            det_count = det_count - 8'd1;
                        else
                            request_move(REQ_SLEEP);
                    end
                    else
                        request_move(REQ_WAKE);
                end
            end
            OP_TAP:
                request_move(REQ_WAKE);
            OP_SW_WAKE:
            begin
                if (allowed)
                    request_move(REQ_WAKE);
            end
            default:
                request_move((!usb && allowed) ? REQ_ENABLE : REQ_DISABLE);
        endcase
        st.mode = det_mode;
        st.mins = det_count;
        st.motion = DIST_W'(motion);
        st.hs = (det_mode == MODE_STATIONARY);
        return st;
    endfunction

    function automatic plan_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] val);
        plan_row_t r;
        r = '0;
        r.is_reg = 1'b1;
        r.idx = idx;
        r.val = val;
        return r;
    endfunction

    function automatic plan_row_t word_row(input logic [OP_W-1:0] op,
                                           input logic [SAMPLE_W-1:0] x,
                                           input logic [SAMPLE_W-1:0] y,
                                           input logic [SAMPLE_W-1:0] z,
                                           input logic usb);
        plan_row_t r;
        r = '0;
        r.op = op;
        r.x = x;
        r.y = y;
        r.z = z;
        r.usb = usb;
        return r;
    endfunction

    // Row whose result is obvious enough to type in directly
    function automatic plan_row_t known_row(input logic [OP_W-1:0] op,
                                            input logic [SAMPLE_W-1:0] x,
                                            input logic [SAMPLE_W-1:0] y,
                                            input logic [SAMPLE_W-1:0] z,
                                            input logic usb,
                                            input logic [MODE_W-1:0] mode,
                                            input logic [COUNT_W-1:0] mins,
                                            input logic [DIST_W-1:0] motion);
        plan_row_t r;
        r = word_row(op, x, y, z, usb);
        r.known = 1'b1;
        r.st.mode = mode;
        r.st.mins = mins;
        r.st.motion = motion;
        r.st.hs = (mode == MODE_STATIONARY);
        return r;
    endfunction

    // Write one register on the idle block and mirror it locally
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_WAIT_MINUTES:    det_wait_min = val[COUNT_W-1:0];
            CFG_PEEK_MINUTES:    det_peek_min = val[COUNT_W-1:0];
            CFG_IDLE_THRESHOLD:  det_threshold = val[DIST_W-1:0];
            CFG_FEATURE_ENABLED: det_feature = val[0];
            CFG_RUNLEVEL_ALLOW:  det_runlevel = val[0];
            default: ;
        endcase
        reg_writes++;
        @(posedge clk);
    endtask

    // Drop valid and hold until every awaited status word has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        while (awaited_status.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Offer one word, hold it until accepted, then queue its expected status
    task automatic send_word(input logic [OP_W-1:0] op,
                             input logic [SAMPLE_W-1:0] x,
                             input logic [SAMPLE_W-1:0] y,
                             input logic [SAMPLE_W-1:0] z,
                             input logic usb,
                             input bit known,
                             input status_t known_st);
        status_t st;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {7'd0, usb, z, y, x};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        st = step_detector(op, x, y, z, usb);
        awaited_status.push_back(known ? known_st : st);
        words_sent++;
    endtask

    // Receiver back-pressure
    always @(posedge clk)
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);

    // Check each result word against the oldest expectation
    always @(posedge clk)
    begin
        status_t got;
        status_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.mode = m_tdata[1:0];
            got.mins = m_tdata[9:2];
            got.motion = m_tdata[27:10];
            got.hs = m_tdata[28];
            results_seen++;
            if (awaited_status.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] unexpected result word %h with nothing pending",
                             $time, m_tdata);
            end
            else
            begin
                want = awaited_status.pop_front();
                if (got.mode !== want.mode || got.mins !== want.mins ||
                    got.motion !== want.motion || got.hs !== want.hs)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("[%0t] mismatch: expected mode %0d min %0d dist %0d hs %0b, got mode %0d min %0d dist %0d hs %0b",
                                 $time, want.mode, want.mins, want.motion, want.hs,
                                 got.mode, got.mins, got.motion, got.hs);
                end
            end
        end
    end

    // Watchdog: end the run if no word moves on either side for too long
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT)
        begin
            $display("timeout: no word accepted for %0d cycles", quiet);
            $display("stationary_inactivity_state_machine_top regression: fail");
            $finish;
        end
    end

    initial
    begin
        int unsigned     ph;
        int unsigned     chunk;
        int unsigned     n;
        int unsigned     pick;
        int unsigned     directed_words;
        logic [OP_W-1:0] op;
        logic [SAMPLE_W-1:0] ax;
        logic [SAMPLE_W-1:0] ay;
        logic [SAMPLE_W-1:0] az;
        logic            usb;
        logic [COUNT_W-1:0] reload;
        logic [DIST_W-1:0]  thr;

        // Directed table: disabled-state behavior, enable gating, distance
        // extremes, countdown reaching zero, peeking and register extremes
        plan.push_back(known_row(OP_TICK, 16'h7FFF, 16'h8000, 16'h0001, 1'b1,
                                 MODE_DISABLED, 8'd30, 18'd0));
        plan.push_back(known_row(OP_SW_WAKE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1,
                                 MODE_DISABLED, 8'd30, 18'd0));
        plan.push_back(known_row(OP_REEVAL, 16'h0, 16'h0, 16'h0, 1'b0,
                                 MODE_DISABLED, 8'd30, 18'd0));
        plan.push_back(known_row(OP_TAP, 16'h0, 16'h0, 16'h0, 1'b0,
                                 MODE_DISABLED, 8'd30, 18'd0));
        plan.push_back(reg_row(CFG_RUNLEVEL_ALLOW, 18'd1));
        plan.push_back(reg_row(CFG_UNUSED_LO, 18'h3FFFF));
        plan.push_back(reg_row(CFG_UNUSED_HI, 18'h0));
        plan.push_back(known_row(OP_REEVAL, 16'h0, 16'h0, 16'h0, 1'b1,
                                 MODE_DISABLED, 8'd30, 18'd0));
        plan.push_back(known_row(OP_REEVAL, 16'h0, 16'h0, 16'h0, 1'b0,
                                 MODE_AWAKE, 8'd30, 18'd0));
        plan.push_back(known_row(OP_TICK, 16'h0, 16'h0, 16'h0, 1'b0,
                                 MODE_AWAKE, 8'd29, 18'd0));
        plan.push_back(known_row(OP_TICK, 16'h7FFF, 16'h8000, 16'h7FFF, 1'b0,
                                 MODE_AWAKE, 8'd30, 18'd98302));
        plan.push_back(known_row(OP_TICK, 16'h8000, 16'h7FFF, 16'h8000, 1'b0,
                                 MODE_AWAKE, 8'd30, 18'd196605));
        plan.push_back(reg_row(CFG_WAIT_MINUTES, 18'd0));
        plan.push_back(known_row(OP_TAP, 16'h0, 16'h0, 16'h0, 1'b0,
                                 MODE_AWAKE, 8'd0, 18'd0));
        plan.push_back(known_row(OP_TICK, 16'h8000, 16'h7FFF, 16'h8000, 1'b0,
                                 MODE_STATIONARY, 8'd0, 18'd0));
        plan.push_back(word_row(OP_TICK, 16'h8000, 16'h7FFF, 16'h8000, 1'b1));
        plan.push_back(reg_row(CFG_PEEK_MINUTES, 18'd255));
        plan.push_back(known_row(OP_SW_WAKE, 16'h0, 16'h0, 16'h0, 1'b0,
                                 MODE_PEEKING, 8'd255, 18'd0));
        plan.push_back(word_row(OP_TICK, 16'h8000, 16'h7FFF, 16'h8000, 1'b0));
        plan.push_back(word_row(OP_TAP, 16'h0, 16'h0, 16'h0, 1'b0));
        plan.push_back(word_row(OP_TICK, 16'h8000, 16'h7FFF, 16'h8000, 1'b0));
        plan.push_back(reg_row(CFG_IDLE_THRESHOLD, 18'd0));
        plan.push_back(word_row(OP_TICK, 16'h8000, 16'h7FFF, 16'h8000, 1'b0));
        plan.push_back(reg_row(CFG_IDLE_THRESHOLD, 18'd196605));
        plan.push_back(word_row(OP_TICK, 16'h7FFF, 16'h8000, 16'h7FFF, 1'b0));
        plan.push_back(word_row(OP_SW_WAKE, 16'h0, 16'h0, 16'h0, 1'b0));
        plan.push_back(reg_row(CFG_FEATURE_ENABLED, 18'd0));
        plan.push_back(word_row(OP_SW_WAKE, 16'h0, 16'h0, 16'h0, 1'b0));
        plan.push_back(word_row(OP_REEVAL, 16'h0, 16'h0, 16'h0, 1'b0));
        plan.push_back(word_row(OP_TICK, 16'h1234, 16'h5678, 16'h9ABC, 1'b0));
        plan.push_back(reg_row(CFG_FEATURE_ENABLED, 18'd1));
        plan.push_back(reg_row(CFG_WAIT_MINUTES, 18'd255));
        plan.push_back(word_row(OP_REEVAL, 16'h0, 16'h0, 16'h0, 1'b0));
        plan.push_back(word_row(OP_TICK, 16'h1235, 16'h5677, 16'h9ABC, 1'b0));

        // Hold reset, then release it
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table; register rows wait for the block to drain
        foreach (plan[i])
        begin
            if (plan[i].is_reg)
            begin
                drain();
                write_reg(plan[i].idx, plan[i].val);
            end
            else
                send_word(plan[i].op, plan[i].x, plan[i].y, plan[i].z, plan[i].usb,
                          plan[i].known, plan[i].st);
        end
        directed_words = words_sent;

        // Random part: four pacing phases, each with four register settings
        for (ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
                default: begin send_idle_pct = 24; recv_stall_pct = 24; end
            endcase
            for (chunk = 0; chunk < 4; chunk++)
            begin
                drain();
                // Mostly short countdowns so sleep and peeking are reached often
                pick = $urandom_range(0, 5);
                reload = (pick == 0) ? 8'd0 : (pick == 1) ? 8'd255 : 8'($urandom_range(1, 6));
                write_reg(CFG_WAIT_MINUTES, 18'(reload));
                pick = $urandom_range(0, 5);
                reload = (pick == 0) ? 8'd0 : (pick == 1) ? 8'd255 : 8'($urandom_range(1, 6));
                write_reg(CFG_PEEK_MINUTES, 18'(reload));
                pick = $urandom_range(0, 5);
                thr = (pick == 0) ? 18'd0 : (pick == 1) ? 18'd196605 :
                      (pick == 2) ? 18'd1 : 18'($urandom_range(8, 120));
                write_reg(CFG_IDLE_THRESHOLD, thr);
                write_reg(CFG_FEATURE_ENABLED, 18'($urandom_range(0, 9) != 0));
                write_reg(CFG_RUNLEVEL_ALLOW, 18'($urandom_range(0, 9) != 0));
                if ($urandom_range(0, 3) == 0)
                    write_reg($urandom_range(0, 1) ? CFG_UNUSED_LO : CFG_UNUSED_HI,
                              18'($urandom));

                for (n = 0; n < CHUNK_WORDS; n++)
                begin
                    // Pause the sender mid-chunk until everything is back
                    if (n == CHUNK_WORDS / 2)
                        drain();
                    pick = $urandom_range(0, 99);
                    if (pick < 70)
                        op = OP_TICK;
                    else if (pick < 78)
                        op = OP_TAP;
                    else if (pick < 86)
                        op = OP_SW_WAKE;
                    else
                        op = OP_REEVAL;
                    // Small drift keeps the device still; some jumps and extremes
                    pick = $urandom_range(0, 19);
                    if (pick < 15)
                    begin
                        ax = det_px + 16'($urandom_range(0, 30)) - 16'd15;
                        ay = det_py + 16'($urandom_range(0, 30)) - 16'd15;
                        az = det_pz + 16'($urandom_range(0, 30)) - 16'd15;
                    end
                    else if (pick < 18)
                    begin
                        ax = 16'($urandom);
                        ay = 16'($urandom);
                        az = 16'($urandom);
                    end
                    else
                    begin
                        ax = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
                        ay = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
                        az = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
                    end
                    usb = ($urandom_range(0, 4) == 0);
                    send_word(op, ax, ay, az, usb, 1'b0, '0);
                end
            end
        end

        // Let the last results come back, then allow for the pipeline tail
        drain();
        repeat (8) @(posedge clk);

        $display("Covered %0d input words (%0d directed), %0d result words, %0d register writes",
                 words_sent, directed_words, results_seen, reg_writes);
        $display("Detector went still %0d times and peeked %0d times over four pacing phases",
                 sleeps, peeks);
        if (mismatches == 0 && awaited_status.size() == 0)
            $display("stationary_inactivity_state_machine_top regression: pass");
        else
            $display("stationary_inactivity_state_machine_top regression: fail");
        $finish;
    end

endmodule

// File: filelist.f
src/sism_pkg.sv
src/sism_cfg.sv
src/sism_dist.sv
src/sism_fsm.sv
src/stationary_inactivity_state_machine_top.sv
tb/sv/tb.sv
